/* hdl/sfk_pkg.sv */
// Shared constants, types and helpers for the skeleton forward kinematics block.
package sfk_pkg;

  localparam int unsigned MAX_BONES = 64;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BONE_W    = $clog2(MAX_BONES);
  localparam int unsigned NUM_ENT   = 12;
  localparam int unsigned ENT_W     = $clog2(NUM_ENT);
  localparam int unsigned MEM_DEPTH = MAX_BONES * NUM_ENT;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned QUAT_W    = 18;
  localparam int unsigned PROD_W    = 2 * QUAT_W;
  localparam int unsigned RAW_W     = PROD_W + 4;
  localparam int unsigned ACC_W     = 64;

  localparam logic signed [31:0]      ONE_Q   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sd1 <<< 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_STORE,
    ST_DONE
  } state_e;

  typedef logic signed [31:0] ent_t;

  // Identity transform entry, used for roots and unwritten parents.
  function automatic ent_t ident_ent(input logic [ENT_W-1:0] idx);
    ent_t v;
    v = '0;
    if (idx == ENT_W'(0) || idx == ENT_W'(5) || idx == ENT_W'(10)) begin
      v = ONE_Q;
    end
    return v;
  endfunction

endpackage

/* hdl/sfk_quat_rot.sv */
// Two-stage quaternion to local rotation matrix converter.
module sfk_quat_rot import sfk_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [QUAT_W-1:0] qw_i,
  input  logic signed [QUAT_W-1:0] qx_i,
  input  logic signed [QUAT_W-1:0] qy_i,
  input  logic signed [QUAT_W-1:0] qz_i,
  output ent_t                     rot_o [9]
);

  localparam logic signed [RAW_W-1:0] ONE_RAW = RAW_W'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [RAW_W-1:0] HALF    = RAW_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [RAW_W-1:0]  raw [9];
  logic signed [RAW_W-1:0]  rnd [9];
  ent_t                     rot_q [9];

  function automatic logic signed [RAW_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return RAW_W'(p);
  endfunction

  always_ff @(posedge clk_i) begin
    xx_q <= qx_i * qx_i;
    yy_q <= qy_i * qy_i;
    zz_q <= qz_i * qz_i;
    xy_q <= qx_i * qy_i;
    xz_q <= qx_i * qz_i;
    yz_q <= qy_i * qz_i;
    wx_q <= qw_i * qx_i;
    wy_q <= qw_i * qy_i;
    wz_q <= qw_i * qz_i;
  end

  always_comb begin
    raw[0] = ONE_RAW - ((ext(yy_q) + ext(zz_q)) <<< 1);
    raw[1] = (ext(xy_q) - ext(wz_q)) <<< 1;
    raw[2] = (ext(xz_q) + ext(wy_q)) <<< 1;
    raw[3] = (ext(xy_q) + ext(wz_q)) <<< 1;
    raw[4] = ONE_RAW - ((ext(xx_q) + ext(zz_q)) <<< 1);
    raw[5] = (ext(yz_q) - ext(wx_q)) <<< 1;
    raw[6] = (ext(xz_q) - ext(wy_q)) <<< 1;
    raw[7] = (ext(yz_q) + ext(wx_q)) <<< 1;
    raw[8] = ONE_RAW - ((ext(xx_q) + ext(yy_q)) <<< 1);
    for (int i = 0; i < 9; i++) begin
      // round half up; the result always fits 32 bits
      rnd[i] = (raw[i] + HALF) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      rot_q[i] <= 32'(rnd[i]);
    end
  end

  assign rot_o = rot_q;

endmodule

/* hdl/skeleton_forward_kinematics.sv */
// Top level of the skeleton forward kinematics block.
// One bone transaction is taken when start_i is high and busy_o is low. The
// block forms the local transform from the quaternion and translation, reads
// the parent's stored 3x4 world transform (identity for a root or a parent
// never written), multiplies the two and writes the world transform back into
// the bone's slot. From acceptance to the done_o strobe the block reads the
// twelve parent entries from the transform memory (one read port, one write
// port), runs the 48 multiply-accumulates on the one 32x32 multiplier, writes
// the result back and then raises done_o. busy_o drops in the cycle after the
// strobe. The outputs keep the result until the next transaction's multiply
// phase; the receiver cannot stall it. Parents must be sent before their
// children. There is no clearing pass: the per-bone written map is cleared
// directly by reset.
module skeleton_forward_kinematics import sfk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [5:0]         bone_index_i,
  input  logic [5:0]         parent_index_i,
  input  logic               has_parent_i,
  input  logic signed [17:0] quat_w_i,
  input  logic signed [17:0] quat_x_i,
  input  logic signed [17:0] quat_y_i,
  input  logic signed [17:0] quat_z_i,
  input  logic signed [31:0] trans_x_i,
  input  logic signed [31:0] trans_y_i,
  input  logic signed [31:0] trans_z_i,
  output logic               done_o,
  output logic signed [31:0] rot_00_o,
  output logic signed [31:0] rot_01_o,
  output logic signed [31:0] rot_02_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] rot_10_o,
  output logic signed [31:0] rot_11_o,
  output logic signed [31:0] rot_12_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] rot_20_o,
  output logic signed [31:0] rot_21_o,
  output logic signed [31:0] rot_22_o,
  output logic signed [31:0] pos_z_o
);

  localparam int unsigned CNT_W  = $clog2(NUM_ENT + 1);
  localparam int unsigned STEP_W = $clog2(NUM_ENT * 4 + 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(32'h7fffffff);
  localparam logic signed [ACC_W-1:0] MIN32 = -(ACC_W'(1) <<< 31);

  state_e state_q, state_d;

  // Transaction fields, held for the whole transaction.
  logic [BONE_W-1:0]       bone_q, par_q;
  logic                    has_par_q;
  logic signed [QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;
  ent_t                    trans_q [3];

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STEP_W-1:0] step_q, step_d;

  ent_t pm_q [NUM_ENT];   // parent world transform
  ent_t res_q [NUM_ENT];  // result world transform
  ent_t loc_rot [9];

  logic [MAX_BONES-1:0] valid_q;
  logic                 use_ident;

  // Transform memory, one 32-bit entry per matrix element.
  ent_t              mem [MEM_DEPTH];
  ent_t              rdata_q;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              mem_we;

  // Multiply-accumulate pipeline.
  logic [ENT_W-1:0]       mac_o;
  logic [1:0]             mac_k;
  ent_t                   mul_a, mul_b;
  logic signed [ACC_W-1:0] prod_q, acc_q, sum, clamped, rounded;
  logic                   pv_q;
  logic [ENT_W-1:0]       po_q;
  logic [1:0]             pk_q;

  sfk_quat_rot u_quat_rot (
    .clk_i (clk_i),
    .qw_i  (qw_q),
    .qx_i  (qx_q),
    .qy_i  (qy_q),
    .qz_i  (qz_q),
    .rot_o (loc_rot)
  );

  function automatic logic [ADDR_W-1:0] slot_base(input logic [BONE_W-1:0] b);
    return ADDR_W'({b, 3'b000}) + ADDR_W'({b, 2'b00});
  endfunction

  assign use_ident = !has_par_q || !valid_q[par_q];
  assign raddr     = slot_base(par_q) + ADDR_W'(cnt_q);
  assign waddr     = slot_base(bone_q) + ADDR_W'(cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_LOAD;
      ST_LOAD:  if (cnt_q == CNT_W'(NUM_ENT)) state_d = ST_MAC;
      ST_MAC:   if (step_q == STEP_W'(NUM_ENT * 4)) state_d = ST_STORE;
      ST_STORE: if (cnt_q == CNT_W'(NUM_ENT - 1)) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    busy_o = 1'b1;
    done_o = 1'b0;
    mem_we = 1'b0;
    cnt_d  = '0;
    step_d = '0;
    unique case (state_q)
      ST_IDLE:  busy_o = 1'b0;
      ST_LOAD:  if (cnt_q != CNT_W'(NUM_ENT)) cnt_d = cnt_q + CNT_W'(1);
      ST_MAC:   if (step_q != STEP_W'(NUM_ENT * 4)) step_d = step_q + STEP_W'(1);
      ST_STORE: begin
        mem_we = 1'b1;
        if (cnt_q != CNT_W'(NUM_ENT - 1)) cnt_d = cnt_q + CNT_W'(1);
      end
      ST_DONE:  done_o = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      valid_q <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      pv_q    <= (state_q == ST_MAC) && (step_q != STEP_W'(NUM_ENT * 4));
      if (state_q == ST_STORE && cnt_q == CNT_W'(NUM_ENT - 1)) begin
        valid_q[bone_q] <= 1'b1;
      end
    end
  end

  // Capture the transaction.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      bone_q     <= bone_index_i;
      par_q      <= parent_index_i;
      has_par_q  <= has_parent_i;
      qw_q       <= quat_w_i;
      qx_q       <= quat_x_i;
      qy_q       <= quat_y_i;
      qz_q       <= quat_z_i;
      trans_q[0] <= trans_x_i;
      trans_q[1] <= trans_y_i;
      trans_q[2] <= trans_z_i;
    end
  end

  // Memory: write during store, registered read during load.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= res_q[cnt_q[ENT_W-1:0]];
    end
    rdata_q <= mem[raddr];
  end

  // Capture parent entries (identity entries for a root or an unwritten parent) in the cycle after their read address.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && cnt_q != '0) begin
      pm_q[ENT_W'(cnt_q - CNT_W'(1))] <= use_ident ?
          ident_ent(ENT_W'(cnt_q - CNT_W'(1))) : rdata_q;
    end
  end

  // Step order: result entry in the upper bits, inner index in the low two.
  assign mac_o = step_q[STEP_W-1:2];
  assign mac_k = step_q[1:0];

  always_comb begin
    mul_a = pm_q[{mac_o[3:2], mac_k}];
    if (mac_k == 2'd3) begin
      mul_b = (mac_o[1:0] == 2'd3) ? ONE_Q : '0;
    end else if (mac_o[1:0] == 2'd3) begin
      mul_b = trans_q[mac_k];
    end else begin
      mul_b = loc_rot[4'(mac_k) * 4'd3 + 4'(mac_o[1:0])];
    end
  end

  always_comb begin
    sum = ((pk_q == 2'd0) ? '0 : acc_q) + prod_q;
    if (sum > ACC_LIM) begin
      clamped = ACC_LIM;
    end else if (sum < -ACC_LIM) begin
      clamped = -ACC_LIM;
    end else begin
      clamped = sum;
    end
    rounded = (clamped + HALF) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    po_q   <= mac_o;
    pk_q   <= mac_k;
    if (pv_q) begin
      acc_q <= clamped;
      if (pk_q == 2'd3) begin
        if (rounded > MAX32) begin
          res_q[po_q] <= 32'sh7fffffff;
        end else if (rounded < MIN32) begin
          res_q[po_q] <= 32'sh80000000;
        end else begin
          res_q[po_q] <= 32'(rounded);
        end
      end
    end
  end

  assign rot_00_o = res_q[0];
  assign rot_01_o = res_q[1];
  assign rot_02_o = res_q[2];
  assign pos_x_o  = res_q[3];
  assign rot_10_o = res_q[4];
  assign rot_11_o = res_q[5];
  assign rot_12_o = res_q[6];
  assign pos_y_o  = res_q[7];
  assign rot_20_o = res_q[8];
  assign rot_21_o = res_q[9];
  assign rot_22_o = res_q[10];
  assign pos_z_o  = res_q[11];

  a_done_after_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_STORE)
    else $error("done without write-back");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_we_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_STORE && !pv_q)
    else $error("write while multiply pipeline active");

  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> valid_q[bone_q])
    else $error("slot not marked written at done");

endmodule
